>>> rtl/core/assert_macros.svh
// Assertion helpers for the timing block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property must hold at every clock edge outside reset.
`define ASSERT_AT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER_AT_CLK(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`endif

>>> rtl/core/jct_pkg.sv
package jct_pkg;

  localparam int unsigned PsPerUmQ24 = 55963;
  localparam logic signed [23:0] VertexNone = -24'sd999000;

  typedef enum logic [1:0] {
    CmdStartEvent = 2'd0,
    CmdVertex     = 2'd1,
    CmdConstit    = 2'd2,
    CmdUnused     = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        vertex_sum_pt2;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [23:0] time_length;
    logic [23:0]        path_length;
    logic               is_photon;
    logic               is_unit_charge;
    logic [15:0]        trans_momentum;
    logic [19:0]        energy;
    logic               last_in_jet;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] photon_time_ps;
    logic               photon_valid;
    logic signed [31:0] charged_time_ps;
    logic               charged_valid;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StSqLoad,
    StSqrt,
    StAccum,
    StPhDivLoad,
    StPhDiv,
    StPhMul,
    StChDivLoad,
    StChDiv,
    StChMul,
    StOut
  } state_e;

endpackage

>>> rtl/core/jet_constituent_timing_top.sv
// Steps: start and vertex items are taken in StIdle; a constituent goes through 3
//   distance squares, square root steps for a photon only, and 1 accumulate.
// The last of a jet then, for each mean with a nonzero divisor, loads and runs
//   the shared divider and a chunked multiply, then goes to the output state.
// Throughput: one item at a time; ready is low while an item is worked.
// Reset: asynchronous, active low; vertex at -999000, sums cleared, charged_pt_min 32.
module jet_constituent_timing_top #(
  parameter int MAX_CONSTITUENTS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jct_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jct_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import jct_pkg::*;

  localparam int CntW = $clog2(MAX_CONSTITUENTS + 1);

  state_e state_q, state_d;
  logic [15:0] pt_min_q;
  in_item_t it_q;
  logic [31:0] best_q;
  logic signed [23:0] vx_q, vy_q, vz_q;
  logic signed [63:0] ph_sum_q;
  logic [31:0] ph_en_q;
  logic signed [47:0] ch_sum_q;
  logic [12:0] ch_cnt_q;
  logic [CntW-1:0] item_cnt_q;
  logic [66:0] sq_v_q, sq_res_q, sq_bit_q;
  logic [1:0] sq_sel_q;
  logic [66:0] sq_acc_q;
  logic [71:0] mq8_q;
  logic [95:0] prod_q;
  logic [1:0] mul_step_q;
  logic neg_q;
  out_item_t res_q;
  out_item_t out_q;
  logic out_v_q;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, pt_min_q} : 32'd0;
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pt_min_q <= 16'd32;
    else if (cfg_wr) pt_min_q <= pwdata[15:0];
  end

  logic in_acc;
  logic out_free;
  assign in_ready_o = (state_q == StIdle);
  assign in_acc = in_valid_i && in_ready_o;
  // the output register can take a new result
  assign out_free = !out_v_q || out_ready_i;

  // shared divider
  logic div_start, div_done;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic [71:0] div_q8;
  jct_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_num),
    .divisor_i(div_den), .done_o(div_done), .quot_q8_o(div_q8)
  );

  // distance squares, one axis a cycle through one multiplier
  logic signed [24:0] dsel;
  logic [49:0] dsq;
  always_comb begin
    case (sq_sel_q)
      2'd0:    dsel = 25'(vx_q) - 25'(it_q.pos_x);
      2'd1:    dsel = 25'(vy_q) - 25'(it_q.pos_y);
      default: dsel = 25'(vz_q) - 25'(it_q.pos_z);
    endcase
    dsq = 50'(dsel * dsel);
  end

  logic [66:0] sq_t;
  assign sq_t = sq_res_q + sq_bit_q;

  logic is_last_sel, charged;
  assign charged = it_q.is_unit_charge && (it_q.trans_momentum > pt_min_q);
  logic signed [47:0] corr;
  assign corr = it_q.is_photon ? (48'(it_q.time_length) - 48'(sq_res_q[25:0]))
                               : (48'(it_q.time_length) - 48'({1'b0, it_q.path_length}));
  assign is_last_sel = it_q.last_in_jet;

  // 72 x 16 multiply in 3 chunks of 24 bits
  logic [39:0] pp;
  always_comb begin
    case (mul_step_q)
      2'd0:    pp = 40'(mq8_q[23:0] * 16'(PsPerUmQ24));
      2'd1:    pp = 40'(mq8_q[47:24] * 16'(PsPerUmQ24));
      default: pp = 40'(mq8_q[71:48] * 16'(PsPerUmQ24));
    endcase
  end
  logic [31:0] ps_mag;
  assign ps_mag = 32'((prod_q + 96'h80000000) >> 32);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc) begin
        unique case (cmd_e'(in_data_i.command))
          CmdConstit: state_d = StSqLoad;
          default:    state_d = StIdle;
        endcase
      end
      StSqLoad: if (sq_sel_q == 2'd2) state_d = it_q.is_photon ? StSqrt : StAccum;
      StSqrt: if (sq_bit_q == '0) state_d = StAccum;
      StAccum: state_d = is_last_sel ? StPhDivLoad : StIdle;
      StPhDivLoad: state_d = (ph_en_q != 0) ? StPhDiv : StChDivLoad;
      StPhDiv: if (div_done) state_d = StPhMul;
      StPhMul: if (mul_step_q == 2'd3) state_d = StChDivLoad;
      StChDivLoad: state_d = (ch_cnt_q != 0) ? StChDiv : StOut;
      StChDiv: if (div_done) state_d = StChMul;
      StChMul: if (mul_step_q == 2'd3) state_d = StOut;
      StOut: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_q == StPhDivLoad && ph_en_q != 0) begin
      div_start = 1'b1;
      div_num = ph_sum_q[63] ? 64'(-ph_sum_q) : ph_sum_q;
      div_den = ph_en_q;
    end
    if (state_q == StChDivLoad && ch_cnt_q != 0) begin
      div_start = 1'b1;
      div_num = ch_sum_q[47] ? 64'(-ch_sum_q) : 64'(ch_sum_q);
      div_den = 32'(ch_cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
      best_q <= '0;
      vx_q <= VertexNone; vy_q <= VertexNone; vz_q <= VertexNone;
      ph_sum_q <= '0; ph_en_q <= '0; ch_sum_q <= '0; ch_cnt_q <= '0;
      item_cnt_q <= '0;
      sq_sel_q <= '0; mul_step_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && out_free) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_acc) begin
          sq_sel_q <= 2'd0;
          unique case (cmd_e'(in_data_i.command))
            CmdStartEvent: begin
              best_q <= '0;
              vx_q <= VertexNone; vy_q <= VertexNone; vz_q <= VertexNone;
              ph_sum_q <= '0; ph_en_q <= '0; ch_sum_q <= '0; ch_cnt_q <= '0;
              item_cnt_q <= '0;
            end
            CmdVertex: if (in_data_i.vertex_sum_pt2 > best_q) begin
              best_q <= in_data_i.vertex_sum_pt2;
              vx_q <= in_data_i.pos_x; vy_q <= in_data_i.pos_y;
              vz_q <= in_data_i.pos_z;
            end
            default: ;
          endcase
        end
        StSqLoad: sq_sel_q <= sq_sel_q + 2'd1;
        StAccum: begin
          if (item_cnt_q < CntW'(MAX_CONSTITUENTS)) begin
            item_cnt_q <= item_cnt_q + 1'b1;
            if (it_q.is_photon) begin
              ph_sum_q <= ph_sum_q + 64'($signed({1'b0, it_q.energy}) * corr);
              ph_en_q <= ph_en_q + 32'(it_q.energy);
            end
            if (charged) begin
              ch_sum_q <= ch_sum_q + corr;
              ch_cnt_q <= ch_cnt_q + 13'd1;
            end
          end
          mul_step_q <= 2'd0;
        end
        StPhMul, StChMul: if (state_q == StPhMul || state_q == StChMul) begin
          mul_step_q <= mul_step_q + 2'd1;
        end
        StOut: begin
          ph_sum_q <= '0; ph_en_q <= '0; ch_sum_q <= '0; ch_cnt_q <= '0;
          item_cnt_q <= '0;
        end
        default: ;
      endcase
      if (state_q == StChDivLoad) mul_step_q <= 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) it_q <= in_data_i;
    if (state_q == StIdle) sq_acc_q <= '0;
    if (state_q == StSqLoad) begin
      sq_acc_q <= sq_acc_q + 67'(dsq);
      if (sq_sel_q == 2'd2) begin
        sq_v_q <= sq_acc_q + 67'(dsq);
        sq_res_q <= '0;
        sq_bit_q <= 67'd1 << 52;
      end
    end
    if (state_q == StSqrt && sq_bit_q != '0) begin
      if (sq_v_q >= sq_t) begin
        sq_v_q <= sq_v_q - sq_t;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else sq_res_q <= sq_res_q >> 1;
      sq_bit_q <= sq_bit_q >> 2;
    end
    if (state_q == StAccum) begin
      res_q <= '0;
      prod_q <= '0;
    end
    if ((state_q == StPhDiv || state_q == StChDiv) && div_done) begin
      mq8_q <= div_q8;
      prod_q <= '0;
      neg_q <= (state_q == StPhDiv) ? ph_sum_q[63] : ch_sum_q[47];
    end
    if ((state_q == StPhMul || state_q == StChMul) && mul_step_q != 2'd3) begin
      prod_q <= prod_q + (96'(pp) << (24 * mul_step_q));
    end
    if (state_q == StPhMul && mul_step_q == 2'd3) begin
      res_q.photon_time_ps <= neg_q ? -ps_mag : ps_mag;
      res_q.photon_valid <= 1'b1;
    end
    if (state_q == StChMul && mul_step_q == 2'd3) begin
      res_q.charged_time_ps <= neg_q ? -ps_mag : ps_mag;
      res_q.charged_valid <= 1'b1;
    end
    if (state_q == StOut && out_free) out_q <= res_q;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `include "assert_macros.svh"
  `ASSERT_AT_CLK(a_busy_no_ready, clk_i, rst_ni, (state_q != StIdle) |-> !in_ready_o)
  `ASSERT_AT_CLK(a_out_from_last, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == StOut))
  `ASSERT_AT_CLK(a_count_cap, clk_i, rst_ni, item_cnt_q <= CntW'(MAX_CONSTITUENTS))
endmodule

>>> rtl/core/jct_divider.sv
// Restoring divider: 64-bit dividend, 32-bit divisor, one quotient bit a cycle.
// Then 8 fraction bits follow from the remainder; rounding added.
module jct_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [71:0] quot_q8_o
);
  import jct_pkg::*;

  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [71:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] div_q, div_d;
  logic [71:0] quo_q, quo_d;
  logic [32:0] trial;
  logic [33:0] diff;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    trial  = {rem_q[31:0], num_q[71]};
    diff   = {1'b0, trial} - {2'b00, div_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 7'd0;
      num_d  = {dividend_i, 8'd0};
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[70:0], 1'b0};
      if (!diff[33]) begin
        rem_d = diff[32:0];
        quo_d = {quo_q[70:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[70:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd71) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  // round to nearest: remainder*2 >= divisor
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= busy_q && (cnt_q == 7'd71);
  end
  assign done_o    = done_q;
  assign quot_q8_o = quo_q + {71'd0, ({rem_q, 1'b0} >= {2'b00, div_q})};

  `include "assert_macros.svh"
  `ASSERT_AT_CLK(a_done_after_busy, clk_i, rst_ni, done_o |-> $past(busy_q))
  `ASSERT_AT_CLK(a_no_start_busy, clk_i, rst_ni, start_i |-> !busy_q)
  `ASSERT_AT_CLK(a_cnt_range, clk_i, rst_ni, busy_q |-> (cnt_q <= 7'd71))
endmodule

>>> tb/jet_constituent_timing_top_tb.sv
`timescale 1ns / 100ps

module jet_constituent_timing_top_tb;
  import jct_pkg::*;

  localparam int MaxConstit = 256;
  localparam logic [1:0] AddrPtMin = 2'd0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_taken = 1'b0;

  jet_constituent_timing_top #(.MAX_CONSTITUENTS(MaxConstit)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [15:0] pt_min;
  logic [31:0] best_pt2;
  logic signed [23:0] vx, vy, vz;
  logic signed [63:0] ph_wsum;
  logic [31:0] ph_esum;
  logic signed [63:0] ch_tsum;
  logic [31:0] ch_cnt;
  int unsigned jet_items;

  in_item_t pending_items[$];
  out_item_t jet_times_q[$];
  int errors = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] mean_to_ps(input logic signed [63:0] s,
                                             input logic [31:0] dv);
    logic neg;
    logic [63:0] mag, q, r, frac, mq8, ps;
    logic [31:0] p;
    neg = s < 0;
    mag = neg ? 64'd0 - s : s;
    q = mag / dv;
    r = mag % dv;
    frac = ((r << 8) + (dv >> 1)) / dv;
    mq8 = (q << 8) + frac;
    ps = (mq8 * 64'(PsPerUmQ24) + (64'd1 << 31)) >> 32;
    p = ps[31:0];
    return neg ? 32'd0 - p : p;
  endfunction

  function automatic void clear_jet();
    ph_wsum = 0;
    ph_esum = 0;
    ch_tsum = 0;
    ch_cnt = 0;
    jet_items = 0;
  endfunction

  function automatic void clear_vertex();
    best_pt2 = 0;
    vx = VertexNone;
    vy = VertexNone;
    vz = VertexNone;
  endfunction

  function automatic void predict_timing(input in_item_t it);
    logic signed [63:0] corr, dx, dy, dz;
    logic [63:0] d2;
    logic charged;
    out_item_t r;
    case (cmd_e'(it.command))
      CmdStartEvent: begin
        clear_vertex();
        clear_jet();
      end
      CmdVertex: begin
        if (it.vertex_sum_pt2 > best_pt2) begin
          best_pt2 = it.vertex_sum_pt2;
          vx = it.pos_x;
          vy = it.pos_y;
          vz = it.pos_z;
        end
      end
      CmdConstit: begin
        charged = it.is_unit_charge && it.trans_momentum > pt_min;
        if (jet_items < MaxConstit) begin
          jet_items++;
          if (it.is_photon) begin
            dx = 64'(vx) - 64'(it.pos_x);
            dy = 64'(vy) - 64'(it.pos_y);
            dz = 64'(vz) - 64'(it.pos_z);
            d2 = dx * dx + dy * dy + dz * dz;
            corr = 64'(it.time_length) - $signed(int_sqrt(d2));
            ph_wsum += $signed({44'd0, it.energy}) * corr;
            ph_esum += it.energy;
          end else begin
            corr = 64'(it.time_length) - $signed({40'd0, it.path_length});
          end
          if (charged) begin
            ch_tsum += corr;
            ch_cnt++;
          end
        end
        if (it.last_in_jet) begin
          r = '0;
          if (ph_esum != 0) begin
            r.photon_time_ps = mean_to_ps(ph_wsum, ph_esum);
            r.photon_valid = 1'b1;
          end
          if (ch_cnt != 0) begin
            r.charged_time_ps = mean_to_ps(ch_tsum, ch_cnt);
            r.charged_valid = 1'b1;
          end
          jet_times_q.push_back(r);
          clear_jet();
        end
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold
      end else if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        in_data_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
      out_ready_i <= $urandom_range(99) >= snk_stall_pct;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t exp_r;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_timing(in_data_i);
      if (out_valid_o && out_ready_i) begin
        if (jet_times_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          exp_r = jet_times_q.pop_front();
          if (out_data_o.photon_time_ps !== exp_r.photon_time_ps)
            report($sformatf("photon_time_ps %0d exp %0d", out_data_o.photon_time_ps,
                             exp_r.photon_time_ps));
          if (out_data_o.photon_valid !== exp_r.photon_valid)
            report("photon_valid");
          if (out_data_o.charged_time_ps !== exp_r.charged_time_ps)
            report($sformatf("charged_time_ps %0d exp %0d", out_data_o.charged_time_ps,
                             exp_r.charged_time_ps));
          if (out_data_o.charged_valid !== exp_r.charged_valid)
            report("charged_valid");
        end
      end
    end
  end

  task automatic write_pt_min(input logic [15:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrPtMin;
    pwdata <= {16'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    pt_min = v;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || jet_times_q.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_item(input logic [1:0] cmd);
    in_item_t it;
    it.command = cmd;
    it.vertex_sum_pt2 = $urandom;
    it.pos_x = ($urandom_range(3) == 0) ? 24'($urandom)
                                        : 24'(int'($urandom_range(4000)) - 2000);
    it.pos_y = ($urandom_range(3) == 0) ? 24'($urandom)
                                        : 24'(int'($urandom_range(4000)) - 2000);
    it.pos_z = ($urandom_range(3) == 0) ? 24'($urandom)
                                        : 24'(int'($urandom_range(4000)) - 2000);
    it.time_length = 24'($urandom);
    it.path_length = 24'($urandom);
    it.is_photon = 1'($urandom_range(1));
    it.is_unit_charge = 1'($urandom_range(1));
    it.trans_momentum = ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(64));
    it.energy = ($urandom_range(3) == 0) ? 20'd0 : 20'($urandom);
    it.last_in_jet = 1'b0;
    return it;
  endfunction

  function automatic void add_event(input int n_vtx, input int n_jets);
    in_item_t it;
    int n;
    pending_items.push_back(rand_item(CmdStartEvent));
    for (int v = 0; v < n_vtx; v++) begin
      it = rand_item(CmdVertex);
      if ($urandom_range(2) == 0) it.vertex_sum_pt2 = $urandom_range(3);
      pending_items.push_back(it);
    end
    for (int j = 0; j < n_jets; j++) begin
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
        it = rand_item($urandom_range(15) == 0 ? CmdUnused : CmdConstit);
        it.last_in_jet = (k == n - 1);
        pending_items.push_back(it);
      end
    end
  endfunction

  initial begin
    in_item_t it;
    pt_min = 16'd32;
    clear_vertex();
    clear_jet();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: no vertex, extremes, photon+charged, unselected, unused command
    it = '0;
    it.command = CmdConstit;
    it.is_photon = 1'b1;
    it.is_unit_charge = 1'b1;
    it.trans_momentum = 16'hFFFF;
    it.energy = 20'hFFFFF;
    it.pos_x = 24'sh7FFFFF;
    it.pos_y = 24'sh800000;
    it.pos_z = 24'sh7FFFFF;
    it.time_length = 24'sh800000;
    it.last_in_jet = 1'b1;
    pending_items.push_back(it);
    it.is_photon = 1'b0;
    it.path_length = 24'hFFFFFF;
    it.time_length = 24'sh7FFFFF;
    pending_items.push_back(it);
    it.trans_momentum = 16'd32;
    pending_items.push_back(it);
    it.command = CmdUnused;
    pending_items.push_back(it);
    it = '0;
    it.command = CmdVertex;
    it.vertex_sum_pt2 = 32'hFFFFFFFF;
    it.pos_x = 24'sh800000;
    it.pos_y = 24'sh7FFFFF;
    it.pos_z = 24'sh800000;
    pending_items.push_back(it);
    it.command = CmdConstit;
    it.is_photon = 1'b1;
    it.energy = 20'd1;
    it.pos_x = 24'sh7FFFFF;
    it.pos_y = 24'sh800000;
    it.pos_z = 24'sh7FFFFF;
    it.time_length = 24'sh7FFFFF;
    pending_items.push_back(it);
    // partial jet discarded by start of event
    it.last_in_jet = 1'b0;
    pending_items.push_back(it);
    pending_items.push_back(rand_item(CmdStartEvent));
    it.last_in_jet = 1'b1;
    it.energy = 20'd0;
    pending_items.push_back(it);
    drain();

    // long jet past the constituent limit
    for (int k = 0; k < MaxConstit + 4; k++) begin
      it = rand_item(CmdConstit);
      it.is_unit_charge = 1'b1;
      it.trans_momentum = 16'hFFFF;
      it.last_in_jet = (k == MaxConstit + 3);
      pending_items.push_back(it);
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0; snk_stall_pct = 0; write_pt_min(16'd0); end
        1: begin src_idle_pct = 76; snk_stall_pct = 0; write_pt_min(16'hFFFF); end
        2: begin src_idle_pct = 0; snk_stall_pct = 76; write_pt_min(16'($urandom)); end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; write_pt_min(16'd32); end
      endcase
      while (pending_items.size() < 130)
        add_event($urandom_range(0, 4), $urandom_range(1, 4));
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
